@@ hdl/mmrb_pkg.sv @@
package mmrb_pkg;

    // internal ram geometry
    localparam int RAM_DEPTH = 2048;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int SIZE_W    = $clog2(RAM_DEPTH + 1);

    // result target codes
    localparam logic [1:0] TGT_INSIDE = 2'd0;
    localparam logic [1:0] TGT_PORT   = 2'd1;
    localparam logic [1:0] TGT_EXT    = 2'd2;

    // configuration register indexes
    localparam logic CFG_EXT_IO   = 1'b0;
    localparam logic CFG_RAM_SIZE = 1'b1;

    // reset values
    localparam logic [15:0] REG_BASE_RST = 16'h1000;
    localparam logic [11:0] RAM_SIZE_RST = 12'd1280;

    typedef struct packed {
        logic [1:0]  target;
        logic [3:0]  port;
        logic [15:0] ext_address;
        logic        ext_write;
        logic [7:0]  ext_data;
        logic [7:0]  read_data;
    } t_result;

    typedef struct packed {
        logic tflg_we;
        logic adctl_we;
        logic init_we;
        logic ram_we;
        logic ram_rd;
    } t_upd;

endpackage

@@ hdl/mmrb_ram.sv @@
module mmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;
endmodule

@@ hdl/mmrb_decode.sv @@
module mmrb_decode (
    input  logic                   i_kind,
    input  logic [15:0]            i_address,
    input  logic [7:0]             i_write_data,
    input  logic                   i_extended_io,
    input  logic [11:0]            i_ram_size,
    input  logic [15:0]            i_register_base,
    input  logic [15:0]            i_ram_base,
    input  logic [7:0]             i_adc_control,
    input  logic [7:0]             i_timer_flags,
    output mmrb_pkg::t_result      o_res,
    output mmrb_pkg::t_upd         o_upd,
    output logic [mmrb_pkg::RAM_AW-1:0] o_ram_idx
);
    import mmrb_pkg::*;

    localparam logic [7:0] OFF_PORT_A = 8'h00;
    localparam logic [7:0] OFF_PORT_B = 8'h04;
    localparam logic [7:0] OFF_PORT_C = 8'h03;
    localparam logic [7:0] OFF_PORT_D = 8'h08;
    localparam logic [7:0] OFF_PORT_E = 8'h0a;
    localparam logic [7:0] OFF_PORT_G = 8'h7e;
    localparam logic [7:0] OFF_PORT_H = 8'h7c;
    localparam logic [7:0] OFF_SPI2   = 8'h8a;
    localparam logic [7:0] OFF_TFLG   = 8'h23;
    localparam logic [7:0] OFF_ADCTL  = 8'h30;
    localparam logic [7:0] OFF_ADR1   = 8'h31;
    localparam logic [7:0] OFF_ADR4   = 8'h34;
    localparam logic [7:0] OFF_INIT   = 8'h3d;
    localparam logic [7:0] OFF_OPT74  = 8'h74;
    localparam logic [7:0] OFF_OPT89  = 8'h89;

    localparam logic [3:0] PORT_A = 4'd0;
    localparam logic [3:0] PORT_B = 4'd1;
    localparam logic [3:0] PORT_C = 4'd2;
    localparam logic [3:0] PORT_D = 4'd3;
    localparam logic [3:0] PORT_E = 4'd4;
    localparam logic [3:0] PORT_G = 4'd5;
    localparam logic [3:0] PORT_H = 4'd6;
    localparam logic [3:0] PORT_SPI2 = 4'd7;

    logic [16:0]       win;
    logic [16:0]       win_end;
    logic              in_win;
    logic [SIZE_W-1:0] size;
    logic [15:0]       ram_off;
    logic              in_ram;
    logic [7:0]        off;
    logic              is_port;
    logic [3:0]        port_no;
    logic [7:0]        adr_sel;
    logic [2:0]        chan;

    always_comb begin
        win     = i_extended_io ? 17'h00100 : 17'h00040;
        win_end = {1'b0, i_register_base} + win;
        in_win  = (i_address >= i_register_base) && ({1'b0, i_address} < win_end);

        // ram_size saturates at the physical depth
        size = ({1'b0, i_ram_size} > (SIZE_W+1)'(RAM_DEPTH)) ? SIZE_W'(RAM_DEPTH)
                                                             : SIZE_W'(i_ram_size);
        ram_off = i_address - i_ram_base;
        in_ram  = (i_address >= i_ram_base) && (ram_off < 16'(size));
        o_ram_idx = ram_off[RAM_AW-1:0];

        off = i_address[7:0];
        is_port = 1'b1;
        unique case (off)
            OFF_PORT_A: port_no = PORT_A;
            OFF_PORT_B: port_no = PORT_B;
            OFF_PORT_C: port_no = PORT_C;
            OFF_PORT_D: port_no = PORT_D;
            OFF_PORT_E: port_no = PORT_E;
            OFF_PORT_G: port_no = PORT_G;
            OFF_PORT_H: port_no = PORT_H;
            OFF_SPI2:   port_no = PORT_SPI2;
            default: begin
                port_no = PORT_A;
                is_port = 1'b0;
            end
        endcase

        // scan mode walks channels within the selected group of four
        adr_sel = off - OFF_ADR1;
        chan = i_adc_control[4] ? {i_adc_control[2], adr_sel[1:0]} : i_adc_control[2:0];

        o_res = '0;
        o_upd = '0;
        if (in_win) begin
            if (is_port) begin
                o_res.target = TGT_PORT;
                o_res.port   = port_no;
                if (i_kind) begin
                    o_res.ext_write = 1'b1;
                    o_res.ext_data  = i_write_data;
                end
            end else if (!i_kind && off >= OFF_ADR1 && off <= OFF_ADR4) begin
                o_res.target = TGT_PORT;
                o_res.port   = {1'b1, chan};
            end else if (i_kind) begin
                o_upd.tflg_we  = (off == OFF_TFLG);
                o_upd.adctl_we = (off == OFF_ADCTL);
                o_upd.init_we  = (off == OFF_INIT);
            end else begin
                priority case (off)
                    OFF_TFLG:  o_res.read_data = i_timer_flags;
                    OFF_ADCTL: o_res.read_data = 8'h80;
                    OFF_OPT74: o_res.read_data = 8'h40;
                    OFF_OPT89: o_res.read_data = 8'h80;
                    default:   o_res.read_data = 8'h00;
                endcase
            end
        end else if (in_ram) begin
            o_upd.ram_we = i_kind;
            o_upd.ram_rd = !i_kind;
        end else begin
            o_res.target      = TGT_EXT;
            o_res.ext_address = i_address;
            if (i_kind) begin
                o_res.ext_write = 1'b1;
                o_res.ext_data  = i_write_data;
            end
        end
    end
endmodule

@@ hdl/mcu_memory_map_and_register_block.sv @@
// a request taken into the request stage is decoded there and captured in the result stage,
//   whose registers drive the result ports, marked by o_strobe
// throughput: one request per cycle; busy is never raised and results cannot be stalled
// reset (i_rst_n low, synchronous): register page 0x1000, ram page 0, A/D control
//   and timer flags 0, extended_io 1, ram_size 1280; ram contents are not cleared
module mcu_memory_map_and_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_strobe,
    output logic [1:0]  o_target,
    output logic [3:0]  o_port,
    output logic [15:0] o_ext_address,
    output logic        o_ext_write,
    output logic [7:0]  o_ext_data,
    output logic [7:0]  o_read_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mmrb_pkg::*;

    // configuration registers
    logic        r_ext_io;
    logic [11:0] r_ram_size;

    // block state
    logic [15:0] r_register_base;
    logic [15:0] r_ram_base;
    logic [7:0]  r_adc_control;
    logic [7:0]  r_timer_flags;

    // request stage
    logic        r_req_vld;
    logic        r_kind;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;

    // result stage
    logic        r_out_vld;
    t_result     r_res;
    logic        r_ram_rd;

    t_result             dec_res;
    t_upd                dec_upd;
    logic [RAM_AW-1:0]   ram_idx;
    logic [7:0]          ram_q;
    logic                req_take;
    logic                cfg_we;

    assign busy     = 1'b0;
    assign req_take = start && !busy;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;

    // register read back
    always_comb begin
        unique case (paddr[2])
            CFG_EXT_IO:   prdata = {31'd0, r_ext_io};
            CFG_RAM_SIZE: prdata = {20'd0, r_ram_size};
            default:      prdata = 32'd0;
        endcase
    end

    // decode of the registered request against the current pages
    mmrb_decode u_decode (
        .i_kind          (r_kind),
        .i_address       (r_addr),
        .i_write_data    (r_wdata),
        .i_extended_io   (r_ext_io),
        .i_ram_size      (r_ram_size),
        .i_register_base (r_register_base),
        .i_ram_base      (r_ram_base),
        .i_adc_control   (r_adc_control),
        .i_timer_flags   (r_timer_flags),
        .o_res           (dec_res),
        .o_upd           (dec_upd),
        .o_ram_idx       (ram_idx)
    );

    // ram write lands at the end of the decode cycle, so the next request
    // reads it back without any forwarding
    mmrb_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_req_vld && dec_upd.ram_we),
        .i_addr  (ram_idx),
        .i_wdata (r_wdata),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_io        <= 1'b1;
            r_ram_size      <= RAM_SIZE_RST;
            r_register_base <= REG_BASE_RST;
            r_ram_base      <= 16'h0000;
            r_adc_control   <= 8'h00;
            r_timer_flags   <= 8'h00;
            r_req_vld       <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (paddr[2])
                    CFG_EXT_IO:   r_ext_io   <= pwdata[0];
                    CFG_RAM_SIZE: r_ram_size <= pwdata[11:0];
                    default: ;
                endcase
            end

            r_req_vld <= req_take;
            r_out_vld <= r_req_vld;

            if (r_req_vld) begin
                if (dec_upd.tflg_we) begin
                    r_timer_flags <= r_wdata;
                end
                if (dec_upd.adctl_we) begin
                    r_adc_control <= r_wdata;
                end
                // init: low nibble is the register page, high nibble the ram page;
                // equal pages push ram up by 0x100
                if (dec_upd.init_we) begin
                    r_register_base <= {r_wdata[3:0], 12'h000};
                    r_ram_base      <= {r_wdata[7:4], 3'b000,
                                        (r_wdata[3:0] == r_wdata[7:4]), 8'h00};
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_kind  <= i_kind;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        r_res    <= dec_res;
        r_ram_rd <= dec_upd.ram_rd;
    end

    assign o_strobe      = r_out_vld;
    assign o_target      = r_res.target;
    assign o_port        = r_res.port;
    assign o_ext_address = r_res.ext_address;
    assign o_ext_write   = r_res.ext_write;
    assign o_ext_data    = r_res.ext_data;
    // ram read data comes out of the ram's own output register
    assign o_read_data   = r_ram_rd ? ram_q : r_res.read_data;

    a_req_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |-> ##2 o_strobe)
        else $error("request did not produce a result two cycles later");

    a_strobe_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_req_vld))
        else $error("result strobe without a decoded request");

    a_ext_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_target != TGT_EXT) |-> (o_ext_address == 16'h0000))
        else $error("forwarded address set on a non-memory access");

    a_rdata_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_target != TGT_INSIDE) |-> (o_read_data == 8'h00))
        else $error("read data returned on a forwarded access");

    a_init_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && dec_upd.init_we) |=>
            (r_register_base[11:0] == 12'h000 && r_ram_base[7:0] == 8'h00))
        else $error("init write left a base off its page");
endmodule
